>>> rtl/anc_pkg.sv
// Shared types, widths and step tables for the 4-bit ADPCM codec.
// No dependencies; imported by anc_addsub and adpcm_nibble_codec.
`timescale 1ns / 1ps

package anc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 15;
    localparam int PTR_W    = 7;
    localparam int ALU_W    = 20;   // holds step * 15 and 4 * |delta| with sign
    localparam int MOVE_W   = 5;

    localparam logic [PTR_W-1:0] IMA_LAST = 7'd88;
    localparam logic [PTR_W-1:0] OKI_LAST = 7'd48;

    // configuration register indexes
    localparam logic REG_VARIANT   = 1'b0;
    localparam logic REG_DIRECTION = 1'b1;

    localparam logic signed [ALU_W-1:0] SAMPLE_MAX = 20'sd32767;
    localparam logic signed [ALU_W-1:0] SAMPLE_MIN = -20'sd32768;

    localparam logic [STEP_W-1:0] IMA_STEP [89] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    localparam logic [STEP_W-1:0] OKI_STEP [49] = '{
        15'd256, 15'd272, 15'd304, 15'd336, 15'd368, 15'd400, 15'd448, 15'd496, 15'd544,
        15'd592, 15'd656, 15'd720, 15'd800, 15'd880, 15'd960, 15'd1056, 15'd1168,
        15'd1280, 15'd1408, 15'd1552, 15'd1712, 15'd1888, 15'd2080, 15'd2288, 15'd2512,
        15'd2768, 15'd3040, 15'd3344, 15'd3680, 15'd4048, 15'd4464, 15'd4912, 15'd5392,
        15'd5936, 15'd6528, 15'd7184, 15'd7904, 15'd8704, 15'd9568, 15'd10528,
        15'd11584, 15'd12736, 15'd14016, 15'd15408, 15'd16960, 15'd18656, 15'd20512,
        15'd22576, 15'd24832
    };

    localparam logic signed [MOVE_W-1:0] PTR_MOVE [8] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    // one request to the shared add/subtract unit
    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } alu_req_t;

endpackage

>>> rtl/adpcm_nibble_codec.sv
// Top level of the IMA/OKI 4-bit ADPCM codec: sequencer, state and ports.
// Depends on anc_pkg and anc_addsub.
//
//   channel   ports                                 carries
//   input     s_valid s_ready s_restart s_code_in   one nibble or sample
//             s_sample_in
//   result    m_valid m_ready m_code_out            code, sample, step index
//             m_sample_out m_step_position
//   config    cfg_wr_en cfg_index cfg_data          codec_variant, direction
//
// Encode finds the quotient bits, skipped when the magnitude saturates at 7,
// then decodes. The single add/subtract unit serves the delta, magnitude and
// saturation test, the quotient bits, the shift-add multiply and the predictor
// update in turn. The next word is taken the cycle after the result is loaded.
// Reset (synchronous, active low) clears state, config, predictor and valid.
// s_ready is high only while the sequencer is idle; a stalled result sits in
// the output register and does not block the next word's acceptance, but the
// sequencer holds in its last state until that register frees.
`timescale 1ns / 1ps

module adpcm_nibble_codec (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic                                cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    input  logic [3:0]                          s_code_in,
    input  logic signed [anc_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [3:0]                          m_code_out,
    output logic signed [anc_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic [anc_pkg::PTR_W-1:0]           m_step_position
);
    import anc_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_LOAD      = 4'd1;
    localparam logic [3:0] ST_ENC_DELTA = 4'd2;
    localparam logic [3:0] ST_ENC_ABS   = 4'd3;
    localparam logic [3:0] ST_ENC_SAT   = 4'd4;
    localparam logic [3:0] ST_ENC_Q2    = 4'd5;
    localparam logic [3:0] ST_ENC_Q1    = 4'd6;
    localparam logic [3:0] ST_ENC_Q0    = 4'd7;
    localparam logic [3:0] ST_DEC_INIT  = 4'd8;
    localparam logic [3:0] ST_DEC_M0    = 4'd9;
    localparam logic [3:0] ST_DEC_M1    = 4'd10;
    localparam logic [3:0] ST_DEC_M2    = 4'd11;
    localparam logic [3:0] ST_SUM       = 4'd12;
    localparam logic [3:0] ST_OUT       = 4'd13;

    logic [3:0]                 state_reg, state_next;
    logic                       variant_reg, variant_next;
    logic                       direction_reg, direction_next;
    logic signed [SAMPLE_W-1:0] pred_reg, pred_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic                       m_valid_reg, m_valid_next;

    logic [STEP_W-1:0]          step_reg, step_next;
    logic signed [ALU_W-1:0]    acc_reg, acc_next;
    logic [3:0]                 code_reg, code_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [3:0]                 m_code_reg, m_code_next;
    logic signed [SAMPLE_W-1:0] m_sample_reg, m_sample_next;
    logic [PTR_W-1:0]           m_ptr_reg, m_ptr_next;

    alu_req_t                   alu_req;
    logic signed [ALU_W-1:0]    alu_result;

    logic [PTR_W-1:0]           last_idx;
    logic [PTR_W-1:0]           sat_idx;
    logic [STEP_W-1:0]          table_step;
    logic signed [ALU_W-1:0]    step_ext;
    logic [SAMPLE_W-1:0]        diff_mag;
    logic signed [PTR_W+1:0]    ptr_sum;
    logic [PTR_W-1:0]           ptr_clamped;

    anc_addsub u_addsub (
        .req    (alu_req),
        .result (alu_result)
    );

    // step lookup with the pointer held to the active table's range
    always_comb begin
        last_idx = variant_reg ? OKI_LAST : IMA_LAST;
        sat_idx  = (ptr_reg > last_idx) ? last_idx : ptr_reg;
        if (variant_reg) begin
            table_step = OKI_STEP[sat_idx[5:0]];
        end else begin
            table_step = IMA_STEP[sat_idx];
        end
    end

    assign step_ext = $signed({{(ALU_W-STEP_W){1'b0}}, step_reg});

    // (step * (2m+1)) >> 3, with the OKI low nibble cleared
    always_comb begin
        diff_mag = acc_reg[SAMPLE_W+2:3];
        if (variant_reg) begin
            diff_mag[3:0] = 4'd0;
        end
    end

    always_comb begin
        ptr_sum = $signed({2'b00, ptr_reg}) + PTR_MOVE[code_reg[2:0]];
        if (ptr_sum < 0) begin
            ptr_clamped = '0;
        end else if (ptr_sum > $signed({2'b00, last_idx})) begin
            ptr_clamped = last_idx;
        end else begin
            ptr_clamped = ptr_sum[PTR_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        variant_next   = variant_reg;
        direction_next = direction_reg;
        pred_next      = pred_reg;
        ptr_next       = ptr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        step_next      = step_reg;
        acc_next       = acc_reg;
        code_next      = code_reg;
        sample_next    = sample_reg;
        m_code_next    = m_code_reg;
        m_sample_next  = m_sample_reg;
        m_ptr_next     = m_ptr_reg;
        alu_req.a      = acc_reg;
        alu_req.b      = '0;
        alu_req.sub    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    code_next   = s_code_in;
                    sample_next = s_sample_in;
                    if (s_restart) begin
                        pred_next = '0;
                        ptr_next  = '0;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                step_next  = table_step;
                state_next = direction_reg ? ST_ENC_DELTA : ST_DEC_INIT;
            end
            ST_ENC_DELTA: begin
                alu_req.a   = ALU_W'(sample_reg);
                alu_req.b   = ALU_W'(pred_reg);
                alu_req.sub = 1'b1;
                acc_next    = alu_result;
                code_next   = {alu_result[ALU_W-1], 3'b000};
                state_next  = ST_ENC_ABS;
            end
            ST_ENC_ABS: begin
                alu_req.a   = '0;
                alu_req.b   = acc_reg;
                alu_req.sub = 1'b1;
                if (code_reg[3]) begin
                    acc_next = alu_result;
                end
                state_next = ST_ENC_SAT;
            end
            ST_ENC_SAT: begin
                // 4|d|/step >= 8 exactly when |d| >= 2 * step
                alu_req.b   = step_ext <<< 1;
                alu_req.sub = 1'b1;
                if (!alu_result[ALU_W-1]) begin
                    code_next[2:0] = 3'b111;
                    state_next     = ST_DEC_INIT;
                end else begin
                    acc_next   = acc_reg <<< 2;
                    state_next = ST_ENC_Q2;
                end
            end
            ST_ENC_Q2, ST_ENC_Q1, ST_ENC_Q0: begin
                // restoring division, one quotient bit per cycle
                alu_req.sub = 1'b1;
                if (state_reg == ST_ENC_Q2) begin
                    alu_req.b = step_ext <<< 2;
                end else if (state_reg == ST_ENC_Q1) begin
                    alu_req.b = step_ext <<< 1;
                end else begin
                    alu_req.b = step_ext;
                end
                if (!alu_result[ALU_W-1]) begin
                    acc_next = alu_result;
                    if (state_reg == ST_ENC_Q2) begin
                        code_next[2] = 1'b1;
                    end else if (state_reg == ST_ENC_Q1) begin
                        code_next[1] = 1'b1;
                    end else begin
                        code_next[0] = 1'b1;
                    end
                end
                if (state_reg == ST_ENC_Q0) begin
                    state_next = ST_DEC_INIT;
                end else begin
                    state_next = state_reg + 4'd1;
                end
            end
            ST_DEC_INIT: begin
                acc_next   = step_ext;
                state_next = ST_DEC_M0;
            end
            ST_DEC_M0: begin
                alu_req.b  = code_reg[0] ? (step_ext <<< 1) : '0;
                acc_next   = alu_result;
                state_next = ST_DEC_M1;
            end
            ST_DEC_M1: begin
                alu_req.b  = code_reg[1] ? (step_ext <<< 2) : '0;
                acc_next   = alu_result;
                state_next = ST_DEC_M2;
            end
            ST_DEC_M2: begin
                alu_req.b  = code_reg[2] ? (step_ext <<< 3) : '0;
                acc_next   = alu_result;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                alu_req.a   = ALU_W'(pred_reg);
                alu_req.b   = $signed({{(ALU_W-SAMPLE_W){1'b0}}, diff_mag});
                alu_req.sub = code_reg[3];
                if (alu_result > SAMPLE_MAX) begin
                    pred_next = SAMPLE_MAX[SAMPLE_W-1:0];
                end else if (alu_result < SAMPLE_MIN) begin
                    pred_next = SAMPLE_MIN[SAMPLE_W-1:0];
                end else begin
                    pred_next = alu_result[SAMPLE_W-1:0];
                end
                ptr_next   = ptr_clamped;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_code_next   = code_reg;
                    m_sample_next = pred_reg;
                    m_ptr_next    = ptr_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // writes must come only while the sequencer is idle (not enforced)
        if (cfg_wr_en) begin
            if (cfg_index == REG_VARIANT) begin
                variant_next = cfg_data;
                pred_next    = '0;
                ptr_next     = '0;
            end else begin
                direction_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            variant_reg   <= 1'b0;
            direction_reg <= 1'b0;
            pred_reg      <= '0;
            ptr_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            variant_reg   <= variant_next;
            direction_reg <= direction_next;
            pred_reg      <= pred_next;
            ptr_reg       <= ptr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        code_reg     <= code_next;
        sample_reg   <= sample_next;
        m_code_reg   <= m_code_next;
        m_sample_reg <= m_sample_next;
        m_ptr_reg    <= m_ptr_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_code_out      = m_code_reg;
    assign m_sample_out    = m_sample_reg;
    assign m_step_position = m_ptr_reg;

endmodule

>>> rtl/anc_addsub.sv
// Shared add/subtract unit driven by the codec sequencer.
// Depends on anc_pkg.
`timescale 1ns / 1ps

module anc_addsub (
    input  anc_pkg::alu_req_t                  req,
    output logic signed [anc_pkg::ALU_W-1:0]   result
);
    import anc_pkg::*;

    assign result = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule
